// File: hw/rtl/delta_queue_task_scheduler_top_defines.svh
// assertion macros for the delta queue task scheduler
`ifndef DELTA_QUEUE_TASK_SCHEDULER_TOP_DEFINES_SVH
`define DELTA_QUEUE_TASK_SCHEDULER_TOP_DEFINES_SVH
`ifndef SYNTHESIS
// property must hold at every clock edge outside reset
`define DQTS_ASSERT(name, prop) \
	name: assert property (@(posedge clk) disable iff (!arst_n) prop) \
	else $error("dqts assertion failed");
// expression must never be true outside reset
`define DQTS_NEVER(name, expr) \
	name: assert property (@(posedge clk) disable iff (!arst_n) !(expr)) \
	else $error("dqts forbidden condition");
`else
`define DQTS_ASSERT(name, prop)
`define DQTS_NEVER(name, expr)
`endif
`endif

// File: hw/rtl/dqts_pkg.sv
// shared types, codes and helpers of the delta queue task scheduler
`default_nettype none
package dqts_pkg;
	localparam int SLOTS = 16;
	localparam int ID_W  = $clog2(SLOTS);
	localparam logic [4:0] SLOT_NONE = 5'(SLOTS);

	typedef enum logic [1:0] {
		OP_TICK     = 2'd0,
		OP_ADD      = 2'd1,
		OP_DELETE   = 2'd2,
		OP_DISPATCH = 2'd3
	} op_t;

	typedef enum logic [1:0] {
		STAT_OK    = 2'd0,
		STAT_FULL  = 2'd1,
		STAT_NODEL = 2'd2,
		STAT_NONE  = 2'd3
	} status_t;

	typedef enum logic [1:0] {
		ERR_NONE  = 2'd0,
		ERR_FULL  = 2'd1,
		ERR_NODEL = 2'd2
	} err_t;

	typedef enum logic [2:0] {
		CELL_HOLD,
		CELL_DEC,
		CELL_POP,
		CELL_INS,
		CELL_REM
	} cell_op_t;

	typedef enum logic [2:0] {
		SLOT_NOP,
		SLOT_CLAIM,
		SLOT_FREE,
		SLOT_INC,
		SLOT_DEC
	} slot_op_t;

	// one queue entry
	typedef struct packed {
		logic            valid;
		logic [ID_W-1:0] id;
		logic [31:0]     delay;
	} cell_t;

	// command broadcast to every cell
	typedef struct packed {
		cell_op_t        op;
		logic [ID_W-1:0] pos;
		logic [ID_W-1:0] new_id;
		logic [31:0]     new_delay;
	} cell_ctl_t;

	// command to the slot table
	typedef struct packed {
		slot_op_t        op;
		logic [ID_W-1:0] sel;
		logic [31:0]     period;
	} slot_cmd_t;

	// index of the lowest set bit, zero when none
	function automatic logic [ID_W-1:0] lowest_idx(input logic [SLOTS-1:0] v);
		logic [ID_W-1:0] r;
		r = '0;
		for (int i = SLOTS - 1; i >= 0; i--) begin
			if (v[i]) r = ID_W'(i);
		end
		return r;
	endfunction
endpackage
`default_nettype wire

// File: hw/rtl/dqts_cell.sv
// one position of the delta queue chain
`default_nettype none
module dqts_cell (
	input  wire logic                   clk,
	input  wire logic                   arst_n,
	input  wire logic [dqts_pkg::ID_W-1:0] idx,
	input  wire dqts_pkg::cell_ctl_t    ctl,
	input  wire dqts_pkg::cell_t        left,
	input  wire dqts_pkg::cell_t        right,
	output dqts_pkg::cell_t             cur
);
	dqts_pkg::cell_t cell_q;

	assign cur = cell_q;

	// shift, insert, remove and decrement as the controller commands
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cell_q <= '0;
		end else begin
			case (ctl.op)
				dqts_pkg::CELL_DEC: begin
					if (idx == '0 && cell_q.valid && cell_q.delay != 32'd0)
						cell_q.delay <= cell_q.delay - 32'd1;
				end
				dqts_pkg::CELL_POP: begin
					cell_q <= right;
				end
				dqts_pkg::CELL_INS: begin
					if (idx == ctl.pos) begin
						cell_q <= '{valid: 1'b1, id: ctl.new_id, delay: ctl.new_delay};
					end else if (idx > ctl.pos) begin
						// the entry just behind the new one gives up the inserted delay
						if (idx - dqts_pkg::ID_W'(1) == ctl.pos)
							cell_q <= '{valid: left.valid, id: left.id,
								delay: left.delay - ctl.new_delay};
						else
							cell_q <= left;
					end
				end
				dqts_pkg::CELL_REM: begin
					if (idx >= ctl.pos) begin
						// the successor absorbs the removed delay
						if (idx == ctl.pos && right.valid)
							cell_q <= '{valid: right.valid, id: right.id,
								delay: right.delay + cell_q.delay};
						else
							cell_q <= right;
					end
				end
				default: begin
					cell_q <= cell_q;
				end
			endcase
		end
	end
endmodule
`default_nettype wire

// File: hw/rtl/dqts_slots.sv
// task slot table: used flag, period and pending count per slot
`default_nettype none
module dqts_slots (
	input  wire logic                          clk,
	input  wire logic                          arst_n,
	input  wire dqts_pkg::slot_cmd_t           cmd,
	input  wire logic [dqts_pkg::ID_W-1:0]     rd_sel,
	output logic [dqts_pkg::SLOTS-1:0]         used,
	output logic [dqts_pkg::SLOTS-1:0]         pend_nz,
	output logic [31:0]                        period_rd
);
	logic        used_q   [dqts_pkg::SLOTS];
	logic [31:0] period_q [dqts_pkg::SLOTS];
	logic [7:0]  pend_q   [dqts_pkg::SLOTS];

	// status vectors for the priority searches
	always_comb begin
		for (int i = 0; i < dqts_pkg::SLOTS; i++) begin
			used[i]    = used_q[i];
			pend_nz[i] = used_q[i] && pend_q[i] != 8'd0;
		end
	end

	assign period_rd = period_q[rd_sel];

	// each entry updates itself when selected
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			for (int i = 0; i < dqts_pkg::SLOTS; i++) begin
				used_q[i]   <= 1'b0;
				period_q[i] <= '0;
				pend_q[i]   <= '0;
			end
		end else begin
			for (int i = 0; i < dqts_pkg::SLOTS; i++) begin
				if (cmd.sel == dqts_pkg::ID_W'(i)) begin
					case (cmd.op)
						dqts_pkg::SLOT_CLAIM: begin
							used_q[i]   <= 1'b1;
							period_q[i] <= cmd.period;
							pend_q[i]   <= '0;
						end
						dqts_pkg::SLOT_FREE: begin
							used_q[i]   <= 1'b0;
							period_q[i] <= '0;
							pend_q[i]   <= '0;
						end
						dqts_pkg::SLOT_INC: begin
							if (used_q[i] && pend_q[i] != 8'd255)
								pend_q[i] <= pend_q[i] + 8'd1;
						end
						dqts_pkg::SLOT_DEC: begin
							pend_q[i] <= pend_q[i] - 8'd1;
						end
						default: begin
							pend_q[i] <= pend_q[i];
						end
					endcase
				end
			end
		end
	end
endmodule
`default_nettype wire

// File: hw/rtl/delta_queue_task_scheduler_top.sv
// Delta queue task scheduler: one command in, one result out per command. The
// queue lives in a chain of 16 cells kept in due order, each holding a slot and
// its delay relative to the cell before it. From decode, a rejected add, a
// rejected delete or a dispatch with nothing due goes straight to the result; a
// delete passes the unlink state, a still-queued dispatch the dispatch state, a
// one-shot dispatch the dispatch and unlink states, a tick the pop state with
// one pop per task falling due, an add the walk state with one step per cell
// passed and a periodic re-queue the dispatch and walk states (at most 15
// cells). The next command is taken the cycle after the result transfer.
`default_nettype none
`include "delta_queue_task_scheduler_top_defines.svh"
module delta_queue_task_scheduler_top (
	input  wire logic        clk,
	input  wire logic        arst_n,
	input  wire logic        s_tvalid,
	output logic             s_tready,
	// first_delay[31:0], repeat_period[63:32], slot_id[67:64]
	input  wire logic [71:0] s_tdata,
	// operation[1:0]
	input  wire logic [1:0]  s_tuser,
	output logic             m_tvalid,
	input  wire logic        m_tready,
	// slot_out[4:0], tick_count[36:5], last_error[38:37]
	output logic [39:0]      m_tdata,
	// status[1:0]
	output logic [1:0]       m_tuser
);
	localparam int ID_W = dqts_pkg::ID_W;
	localparam int SLOTS = dqts_pkg::SLOTS;

	typedef enum logic [6:0] {
		S_IDLE   = 7'b0000001,
		S_DECODE = 7'b0000010,
		S_POP    = 7'b0000100,
		S_WALK   = 7'b0001000,
		S_UNLINK = 7'b0010000,
		S_DISP   = 7'b0100000,
		S_RESP   = 7'b1000000
	} state_t;

	state_t            state_q;
	dqts_pkg::op_t     op_q;
	logic [31:0]       d_q;
	logic [31:0]       per_q;
	logic [3:0]        sid_q;
	logic [ID_W-1:0]   sel_q;
	logic [ID_W-1:0]   p_q;
	logic [31:0]       ticks_q;
	dqts_pkg::err_t    err_q;
	dqts_pkg::status_t status_q;
	logic [4:0]        slot_q;

	dqts_pkg::cell_t     cells [SLOTS];
	dqts_pkg::cell_ctl_t cell_ctl;
	dqts_pkg::slot_cmd_t slot_cmd;
	logic [SLOTS-1:0]    used_vec;
	logic [SLOTS-1:0]    pend_vec;
	logic [SLOTS-1:0]    match_vec;
	logic [31:0]         period_sel;

	// cell chain
	for (genvar k = 0; k < SLOTS; k++) begin : g_cell
		dqts_pkg::cell_t left_nb;
		dqts_pkg::cell_t right_nb;
		if (k == 0) begin : g_first
			assign left_nb = '0;
		end else begin : g_mid_l
			assign left_nb = cells[k-1];
		end
		if (k == SLOTS - 1) begin : g_last
			assign right_nb = '0;
		end else begin : g_mid_r
			assign right_nb = cells[k+1];
		end
		dqts_cell u_cell (
			.clk    (clk),
			.arst_n (arst_n),
			.idx    (ID_W'(k)),
			.ctl    (cell_ctl),
			.left   (left_nb),
			.right  (right_nb),
			.cur    (cells[k])
		);
	end

	dqts_slots u_slots (
		.clk       (clk),
		.arst_n    (arst_n),
		.cmd       (slot_cmd),
		.rd_sel    (sel_q),
		.used      (used_vec),
		.pend_nz   (pend_vec),
		.period_rd (period_sel)
	);

	// searches and walk decisions
	logic            free_any, pend_any, match_any, sid_ok, walk_adv, head_due;
	logic [ID_W-1:0] free_idx, pend_idx, match_idx;
	dqts_pkg::cell_t walk_c, head;

	always_comb begin
		for (int k = 0; k < SLOTS; k++)
			match_vec[k] = cells[k].valid && cells[k].id == sel_q;
	end

	assign free_any  = ~&used_vec;
	assign free_idx  = dqts_pkg::lowest_idx(~used_vec);
	assign pend_any  = |pend_vec;
	assign pend_idx  = dqts_pkg::lowest_idx(pend_vec);
	assign match_any = |match_vec;
	assign match_idx = dqts_pkg::lowest_idx(match_vec);
	assign sid_ok    = (32'(sid_q) < SLOTS) && used_vec[ID_W'(sid_q)];
	assign walk_c    = cells[p_q];
	assign head      = cells[0];
	assign head_due  = head.valid && head.delay == 32'd0;
	assign walk_adv  = walk_c.valid && d_q >= walk_c.delay && p_q != ID_W'(SLOTS - 1);

	// commands to the chain and the slot table
	always_comb begin
		cell_ctl = '{op: dqts_pkg::CELL_HOLD, pos: p_q, new_id: sel_q, new_delay: d_q};
		slot_cmd = '{op: dqts_pkg::SLOT_NOP, sel: sel_q, period: per_q};
		case (state_q)
			S_DECODE: begin
				case (op_q)
					dqts_pkg::OP_TICK: cell_ctl.op = dqts_pkg::CELL_DEC;
					dqts_pkg::OP_ADD: begin
						if (free_any) begin
							slot_cmd.op  = dqts_pkg::SLOT_CLAIM;
							slot_cmd.sel = free_idx;
						end
					end
					dqts_pkg::OP_DELETE: begin
						if (sid_ok) begin
							slot_cmd.op  = dqts_pkg::SLOT_FREE;
							slot_cmd.sel = ID_W'(sid_q);
						end
					end
					default: begin
						if (pend_any) begin
							slot_cmd.op  = dqts_pkg::SLOT_DEC;
							slot_cmd.sel = pend_idx;
						end
					end
				endcase
			end
			S_DISP: begin
				if (period_sel == 32'd0) slot_cmd.op = dqts_pkg::SLOT_FREE;
			end
			S_UNLINK: begin
				if (match_any) begin
					cell_ctl.op  = dqts_pkg::CELL_REM;
					cell_ctl.pos = match_idx;
				end
			end
			S_POP: begin
				if (head_due) begin
					cell_ctl.op  = dqts_pkg::CELL_POP;
					slot_cmd.op  = dqts_pkg::SLOT_INC;
					slot_cmd.sel = head.id;
				end
			end
			S_WALK: begin
				if (!walk_adv) cell_ctl.op = dqts_pkg::CELL_INS;
			end
			default: begin
				cell_ctl.op = dqts_pkg::CELL_HOLD;
			end
		endcase
	end

	// command sequencer
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q  <= S_IDLE;
			ticks_q  <= '0;
			err_q    <= dqts_pkg::ERR_NONE;
			status_q <= dqts_pkg::STAT_OK;
			slot_q   <= dqts_pkg::SLOT_NONE;
			op_q     <= dqts_pkg::OP_TICK;
			d_q      <= '0;
			per_q    <= '0;
			sid_q    <= '0;
			sel_q    <= '0;
			p_q      <= '0;
		end else begin
			case (state_q)
				S_IDLE: begin
					if (s_tvalid) begin
						op_q    <= dqts_pkg::op_t'(s_tuser);
						d_q     <= s_tdata[31:0];
						per_q   <= s_tdata[63:32];
						sid_q   <= s_tdata[67:64];
						state_q <= S_DECODE;
					end
				end
				S_DECODE: begin
					status_q <= dqts_pkg::STAT_OK;
					slot_q   <= dqts_pkg::SLOT_NONE;
					case (op_q)
						dqts_pkg::OP_TICK: begin
							ticks_q <= ticks_q + 32'd1;
							state_q <= S_POP;
						end
						dqts_pkg::OP_ADD: begin
							if (free_any) begin
								sel_q   <= free_idx;
								slot_q  <= 5'(free_idx);
								p_q     <= '0;
								state_q <= S_WALK;
							end else begin
								status_q <= dqts_pkg::STAT_FULL;
								err_q    <= dqts_pkg::ERR_FULL;
								state_q  <= S_RESP;
							end
						end
						dqts_pkg::OP_DELETE: begin
							if (sid_ok) begin
								sel_q   <= ID_W'(sid_q);
								state_q <= S_UNLINK;
							end else begin
								status_q <= dqts_pkg::STAT_NODEL;
								err_q    <= dqts_pkg::ERR_NODEL;
								state_q  <= S_RESP;
							end
						end
						default: begin
							if (pend_any) begin
								sel_q   <= pend_idx;
								slot_q  <= 5'(pend_idx);
								state_q <= S_DISP;
							end else begin
								status_q <= dqts_pkg::STAT_NONE;
								state_q  <= S_RESP;
							end
						end
					endcase
				end
				S_DISP: begin
					if (period_sel != 32'd0) begin
						if (match_any) begin
							state_q <= S_RESP;
						end else begin
							d_q     <= period_sel;
							p_q     <= '0;
							state_q <= S_WALK;
						end
					end else begin
						state_q <= S_UNLINK;
					end
				end
				S_UNLINK: state_q <= S_RESP;
				S_POP: begin
					if (!head_due) state_q <= S_RESP;
				end
				S_WALK: begin
					if (walk_adv) begin
						d_q <= d_q - walk_c.delay;
						p_q <= p_q + ID_W'(1);
					end else begin
						state_q <= S_RESP;
					end
				end
				S_RESP: begin
					if (m_tready) state_q <= S_IDLE;
				end
				default: state_q <= S_IDLE;
			endcase
		end
	end

	// ports
	assign s_tready = state_q == S_IDLE;
	assign m_tvalid = state_q == S_RESP;
	assign m_tuser  = status_q;
	assign m_tdata  = {1'b0, err_q, ticks_q, slot_q};

	// checks
	`DQTS_ASSERT(a_no_overlap, (s_tvalid && s_tready) |-> !m_tvalid)
	`DQTS_ASSERT(a_ready_after_result, (m_tvalid && m_tready) |=> s_tready)
	`DQTS_NEVER(a_chain_packed, !cells[0].valid && cells[1].valid)
endmodule
`default_nettype wire

// File: sim/testbench.sv
// self-checking testbench for the delta queue task scheduler
`default_nettype none
module testbench;
	timeunit 1ns;
	timeprecision 1ps;

	localparam int STALL_LIMIT = 20000;

	typedef struct packed {
		dqts_pkg::op_t op;
		logic [31:0]   first_delay;
		logic [31:0]   repeat_period;
		logic [3:0]    slot_id;
	} command_t;

	typedef struct packed {
		dqts_pkg::status_t status;
		logic [4:0]        slot_out;
		logic [31:0]       tick_count;
		dqts_pkg::err_t    last_error;
	} outcome_t;

	logic        clk = 1'b0;
	logic        arst_n = 1'b0;
	logic        s_tvalid = 1'b0;
	logic        s_tready;
	logic [71:0] s_tdata = '0;
	logic [1:0]  s_tuser = '0;
	logic        m_tvalid;
	logic        m_tready = 1'b0;
	logic [39:0] m_tdata;
	logic [1:0]  m_tuser;

	command_t pending_cmds[$];
	outcome_t expected_outcomes[$];
	int       send_idle_pct = 11;
	int       recv_idle_pct = 83;
	int       hold_off_cycles = 0;
	int       errors = 0;
	int       quiet_cycles = 0;

	// scheduler shadow state
	logic           sh_used[dqts_pkg::SLOTS];
	logic [31:0]    sh_period[dqts_pkg::SLOTS];
	logic [7:0]     sh_runs[dqts_pkg::SLOTS];
	logic [4:0]     sh_next[dqts_pkg::SLOTS];
	logic [31:0]    sh_delay[dqts_pkg::SLOTS];
	logic [4:0]     sh_head;
	logic [31:0]    sh_ticks;
	dqts_pkg::err_t sh_err;

	delta_queue_task_scheduler_top DUT (.*);

	always #6 clk = ~clk;

	function automatic bit queued(input int id);
		logic [4:0] cur;
		cur = sh_head;
		for (int n = 0; n < dqts_pkg::SLOTS && cur != dqts_pkg::SLOT_NONE; n++) begin
			if (cur == id) return 1;
			cur = sh_next[cur];
		end
		return 0;
	endfunction

	// insert by delay, keeping deltas relative
	function automatic void insert_by_delay(input int id, input logic [31:0] dly);
		logic [4:0]  prev, cur;
		logic [31:0] d;
		prev = dqts_pkg::SLOT_NONE;
		cur = sh_head;
		d = dly;
		for (int n = 0; n < dqts_pkg::SLOTS && cur != dqts_pkg::SLOT_NONE
				&& d >= sh_delay[cur]; n++) begin
			d -= sh_delay[cur];
			prev = cur;
			cur = sh_next[cur];
		end
		sh_delay[id] = d;
		sh_next[id] = cur;
		if (prev == dqts_pkg::SLOT_NONE) sh_head = 5'(id);
		else sh_next[prev] = 5'(id);
		if (cur != dqts_pkg::SLOT_NONE) sh_delay[cur] -= d;
	endfunction

	function automatic void unlink(input int id);
		logic [4:0] prev, cur, nxt;
		prev = dqts_pkg::SLOT_NONE;
		cur = sh_head;
		for (int n = 0; n < dqts_pkg::SLOTS && cur != dqts_pkg::SLOT_NONE; n++) begin
			if (cur == id) begin
				nxt = sh_next[cur];
				if (nxt != dqts_pkg::SLOT_NONE) sh_delay[nxt] += sh_delay[cur];
				if (prev != dqts_pkg::SLOT_NONE) sh_next[prev] = nxt;
				else sh_head = nxt;
				sh_next[cur] = dqts_pkg::SLOT_NONE;
				sh_delay[cur] = 0;
				return;
			end
			prev = cur;
			cur = sh_next[cur];
		end
	endfunction

	function automatic void release_slot(input int id);
		unlink(id);
		sh_used[id] = 0;
		sh_period[id] = 0;
		sh_runs[id] = 0;
	endfunction

	function automatic outcome_t schedule_step(input command_t c);
		outcome_t r;
		int i;
		logic [4:0] id;
		r.status = dqts_pkg::STAT_OK;
		r.slot_out = dqts_pkg::SLOT_NONE;
		case (c.op)
			dqts_pkg::OP_TICK: begin
				sh_ticks++;
				if (sh_head != dqts_pkg::SLOT_NONE) begin
					if (sh_delay[sh_head] > 0) sh_delay[sh_head]--;
					for (int n = 0; n < dqts_pkg::SLOTS && sh_head != dqts_pkg::SLOT_NONE
							&& sh_delay[sh_head] == 0; n++) begin
						id = sh_head;
						sh_head = sh_next[id];
						sh_next[id] = dqts_pkg::SLOT_NONE;
						if (sh_used[id] && sh_runs[id] < 8'd255) sh_runs[id]++;
					end
				end
			end
			dqts_pkg::OP_ADD: begin
				for (i = 0; i < dqts_pkg::SLOTS && sh_used[i]; i++) ;
				if (i >= dqts_pkg::SLOTS) begin
					r.status = dqts_pkg::STAT_FULL;
					sh_err = dqts_pkg::ERR_FULL;
				end else begin
					sh_used[i] = 1;
					sh_period[i] = c.repeat_period;
					sh_runs[i] = 0;
					insert_by_delay(i, c.first_delay);
					r.slot_out = 5'(i);
				end
			end
			dqts_pkg::OP_DELETE: begin
				if (!sh_used[c.slot_id]) begin
					r.status = dqts_pkg::STAT_NODEL;
					sh_err = dqts_pkg::ERR_NODEL;
				end else release_slot(c.slot_id);
			end
			default: begin
				for (i = 0; i < dqts_pkg::SLOTS && !(sh_used[i] && sh_runs[i] > 0); i++) ;
				if (i >= dqts_pkg::SLOTS) r.status = dqts_pkg::STAT_NONE;
				else begin
					sh_runs[i]--;
					r.slot_out = 5'(i);
					if (sh_period[i] > 0) begin
						if (!queued(i)) insert_by_delay(i, sh_period[i]);
					end else release_slot(i);
				end
			end
		endcase
		r.tick_count = sh_ticks;
		r.last_error = sh_err;
		return r;
	endfunction

	// driver: take the next pending command after each transfer
	always @(posedge clk) begin
		if (arst_n) begin
			if (!s_tvalid || s_tready) begin
				if (pending_cmds.size() > 0 && $urandom_range(99) >= send_idle_pct) begin
					command_t c;
					c = pending_cmds.pop_front();
					s_tvalid <= 1'b1;
					s_tdata <= {4'b0, c.slot_id, c.repeat_period, c.first_delay};
					s_tuser <= c.op;
				end else s_tvalid <= 1'b0;
			end
		end
	end

	// predictor runs on each accepted command
	always @(posedge clk) begin
		if (arst_n && s_tvalid && s_tready) begin
			command_t c;
			c.op = dqts_pkg::op_t'(s_tuser);
			c.first_delay = s_tdata[31:0];
			c.repeat_period = s_tdata[63:32];
			c.slot_id = s_tdata[67:64];
			expected_outcomes.push_back(schedule_step(c));
		end
	end

	// receiver stall, with an optional long hold-off
	always @(posedge clk) begin
		if (arst_n) begin
			if (hold_off_cycles > 0) begin
				hold_off_cycles <= hold_off_cycles - 1;
				m_tready <= 1'b0;
			end else m_tready <= ($urandom_range(99) >= recv_idle_pct);
		end
	end

	// monitor: compare each result transfer with the oldest expectation
	always @(posedge clk) begin
		if (arst_n && m_tvalid && m_tready) begin
			outcome_t e;
			if (expected_outcomes.size() == 0) begin
				$error("result transfer with nothing expected");
				errors++;
			end else begin
				e = expected_outcomes.pop_front();
				if (m_tuser != e.status) begin
					$error("status expected %0d got %0d", e.status, m_tuser);
					errors++;
				end
				if (m_tdata[4:0] != e.slot_out) begin
					$error("slot_out expected %0d got %0d", e.slot_out, m_tdata[4:0]);
					errors++;
				end
				if (m_tdata[36:5] != e.tick_count) begin
					$error("tick_count expected %0d got %0d", e.tick_count, m_tdata[36:5]);
					errors++;
				end
				if (m_tdata[38:37] != e.last_error) begin
					$error("last_error expected %0d got %0d", e.last_error, m_tdata[38:37]);
					errors++;
				end
			end
		end
	end

	// watchdog on cycles without any transfer
	always @(posedge clk) begin
		if ((s_tvalid && s_tready) || (m_tvalid && m_tready)) quiet_cycles <= 0;
		else if (arst_n) quiet_cycles <= quiet_cycles + 1;
		if (quiet_cycles >= STALL_LIMIT) begin
			$display("Regression FAIL");
			$finish;
		end
	end

	function automatic logic [31:0] rand_delay();
		case ($urandom_range(9))
			0: return 32'hFFFF_FFFF;
			1: return $urandom;
			2: return 0;
			default: return $urandom_range(12);
		endcase
	endfunction

	function automatic command_t make_cmd(input dqts_pkg::op_t op, input logic [31:0] d,
			input logic [31:0] p, input logic [3:0] s);
		command_t c;
		c.op = op;
		c.first_delay = d;
		c.repeat_period = p;
		c.slot_id = s;
		return c;
	endfunction

	task automatic queue_random(input int count);
		int k;
		for (int n = 0; n < count; n++) begin
			k = $urandom_range(99);
			if (k < 40) pending_cmds.push_back(make_cmd(dqts_pkg::OP_TICK, $urandom,
				$urandom, 4'($urandom)));
			else if (k < 62) pending_cmds.push_back(make_cmd(dqts_pkg::OP_ADD, rand_delay(),
				($urandom_range(2) == 0) ? 32'd0 : rand_delay(), 4'($urandom)));
			else if (k < 72) pending_cmds.push_back(make_cmd(dqts_pkg::OP_DELETE, $urandom,
				$urandom, 4'($urandom)));
			else pending_cmds.push_back(make_cmd(dqts_pkg::OP_DISPATCH, $urandom, $urandom,
				4'($urandom)));
		end
	endtask

	task automatic drain();
		while (pending_cmds.size() > 0 || expected_outcomes.size() > 0) @(posedge clk);
		repeat (60) @(posedge clk);
	endtask

	initial begin
		for (int i = 0; i < dqts_pkg::SLOTS; i++) begin
			sh_used[i] = 0;
			sh_period[i] = 0;
			sh_runs[i] = 0;
			sh_next[i] = dqts_pkg::SLOT_NONE;
			sh_delay[i] = 0;
		end
		sh_head = dqts_pkg::SLOT_NONE;
		sh_ticks = 0;
		sh_err = dqts_pkg::ERR_NONE;
		repeat (3) @(posedge clk);
		arst_n <= 1'b1;

		// directed: empty cases, extremes, zero delay, nearly full table, bad delete
		pending_cmds.push_back(make_cmd(dqts_pkg::OP_DISPATCH, 0, 0, 0));
		pending_cmds.push_back(make_cmd(dqts_pkg::OP_DELETE, 0, 0, 4'hF));
		pending_cmds.push_back(make_cmd(dqts_pkg::OP_TICK, 32'hFFFF_FFFF, 32'hFFFF_FFFF,
			4'hF));
		pending_cmds.push_back(make_cmd(dqts_pkg::OP_ADD, 0, 1, 0));
		pending_cmds.push_back(make_cmd(dqts_pkg::OP_ADD, 0, 0, 0));
		pending_cmds.push_back(make_cmd(dqts_pkg::OP_ADD, 32'hFFFF_FFFF, 32'hFFFF_FFFF, 0));
		pending_cmds.push_back(make_cmd(dqts_pkg::OP_ADD, 2, 0, 0));
		pending_cmds.push_back(make_cmd(dqts_pkg::OP_TICK, 0, 0, 0));
		pending_cmds.push_back(make_cmd(dqts_pkg::OP_DISPATCH, 0, 0, 0));
		pending_cmds.push_back(make_cmd(dqts_pkg::OP_DISPATCH, 0, 0, 0));
		pending_cmds.push_back(make_cmd(dqts_pkg::OP_TICK, 0, 0, 0));
		pending_cmds.push_back(make_cmd(dqts_pkg::OP_TICK, 0, 0, 0));
		pending_cmds.push_back(make_cmd(dqts_pkg::OP_DELETE, 0, 0, 2));
		for (int i = 0; i < 11; i++)
			pending_cmds.push_back(make_cmd(dqts_pkg::OP_ADD, i, 3, 0));
		pending_cmds.push_back(make_cmd(dqts_pkg::OP_ADD, 1, 1, 0));
		queue_random(150);
		drain();

		// receiver fast; long hold-off with a dense sender fills the block, then sender sparse
		send_idle_pct = 83;
		recv_idle_pct = 11;
		hold_off_cycles = 400;
		send_idle_pct = 0;
		queue_random(40);
		drain();
		send_idle_pct = 83;
		queue_random(130);
		drain();

		// long tick run on one periodic slot
		send_idle_pct = 0;
		recv_idle_pct = 0;
		for (int i = 0; i < dqts_pkg::SLOTS; i++)
			pending_cmds.push_back(make_cmd(dqts_pkg::OP_DELETE, 0, 0, 4'(i)));
		pending_cmds.push_back(make_cmd(dqts_pkg::OP_ADD, 1, 1, 0));
		for (int i = 0; i < 270; i++)
			pending_cmds.push_back(make_cmd(dqts_pkg::OP_TICK, 0, 0, 0));
		for (int i = 0; i < 3; i++)
			pending_cmds.push_back(make_cmd(dqts_pkg::OP_DISPATCH, 0, 0, 0));
		queue_random(150);
		drain();

		if (errors == 0 && expected_outcomes.size() == 0) $display("Regression PASS");
		else $display("Regression FAIL");
		$finish;
	end
endmodule
`default_nettype wire
